// ===== design/archive_word_cipher_and_hash_unit_defines.svh =====
// Assertion macros for the archive word cipher and hash unit.
// Used by the top level; expects i_clk and i_rst_n in the enclosing scope.
`ifndef ARCHIVE_WORD_CIPHER_AND_HASH_UNIT_DEFINES_SVH
`define ARCHIVE_WORD_CIPHER_AND_HASH_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define AWCH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("awch check failed");
// next-cycle implication
`define AWCH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("awch check failed");
`else
`define AWCH_ASSERT_IMP(lbl, ante, cons)
`define AWCH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/awch_pkg.sv =====
// Package for the archive word cipher and hash unit: constants, types and
// the byte fold and key step functions. No dependencies.
package awch_pkg;

    localparam int WORD_W    = 32;
    localparam int ROM_DEPTH = 1280;
    localparam int ROM_AW    = 11;
    localparam int BYTE_W    = 8;

    // table generator: s = (s * 125 + 3) mod 0x2AAAAB, with 0x2AAAAB = (2^23 + 1) / 3
    localparam int               LCG_W      = 22;
    localparam int               LCG_XW     = 29;
    localparam int               LCG_QW     = 7;
    localparam int               LCG_DW     = 23;
    localparam int               LCG_QSHIFT = 23;
    localparam logic [LCG_W-1:0] LCG_SEED   = 22'h100001;
    localparam logic [LCG_W-1:0] LCG_MOD    = 22'h2AAAAB;
    localparam int               LCG_MUL    = 125;
    localparam int               LCG_ADD    = 3;
    localparam int               COL_W      = 8;
    localparam int               ROW_W      = 3;
    localparam logic [ROW_W-1:0] ROW_LAST   = 3'd4;
    localparam logic [COL_W-1:0] COL_LAST   = 8'hFF;

    localparam logic [WORD_W-1:0] HASH_ONE_INIT = 32'h7FED7FED;
    localparam logic [WORD_W-1:0] SEED_TWO_INIT = 32'hEEEEEEEE;
    localparam logic [WORD_W-1:0] KEY_ADD       = 32'h11111111;
    localparam logic [WORD_W-1:0] SEED_ADD      = 32'd3;
    localparam int                KEY_SHL       = 21;
    localparam int                KEY_SHR       = 11;
    localparam int                SEED_SHL      = 5;
    // decrypt lookups use table quarter 0x400
    localparam logic [ROM_AW-BYTE_W-1:0] KEY_QUARTER = 3'b100;

    localparam logic [BYTE_W-1:0] CHAR_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_BELOW_A = 8'h60;
    localparam logic [BYTE_W-1:0] CHAR_ABOVE_Z = 8'h7B;
    localparam logic [BYTE_W-1:0] CASE_DELTA  = 8'h20;

    localparam logic ACT_DECRYPT = 1'b0;
    localparam logic ACT_HASH    = 1'b1;

    typedef enum logic [2:0] {
        FILL_MUL,
        FILL_QUO,
        FILL_REM,
        FILL_FIX,
        FILL_DONE
    } t_fill_state;

    typedef struct packed {
        logic              we;
        logic [ROM_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_fill_wr;

    typedef struct packed {
        logic              action;
        logic              start;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] data;
        logic [BYTE_W-1:0] chr;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is_hash;
    } t_result;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] f;
        f = (c == CHAR_SLASH) ? CHAR_BSLASH : c;
        if (f > CHAR_BELOW_A && f < CHAR_ABOVE_Z) begin
            f = f - CASE_DELTA;
        end
        return f;
    endfunction

    function automatic logic [WORD_W-1:0] key_next(input logic [WORD_W-1:0] k);
        return ((~k << KEY_SHL) + KEY_ADD) | (k >> KEY_SHR);
    endfunction

endpackage

// ===== design/awch_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module awch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1280
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/awch_fill.sv =====
// Crypt table fill sequencer: runs the table generator after reset and
// writes the 1280 words. Depends on awch_pkg.
module awch_fill (
    input  logic               i_clk,
    input  logic               i_rst_n,
    output awch_pkg::t_fill_wr o_wr,
    output logic               o_done
);
    import awch_pkg::*;

    t_fill_state        r_state, n_state;
    logic [LCG_W-1:0]   r_seed;
    logic [LCG_XW-1:0]  r_x;
    logic [LCG_QW-1:0]  r_q;
    logic [LCG_DW-1:0]  r_d;
    logic [15:0]        r_hi;
    logic               r_phase;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [LCG_W-1:0]   fix;
    logic               last;

    // the quotient estimate is exact or one too high: add the modulus back if negative
    assign fix  = r_d[LCG_DW-1] ? LCG_W'(r_d + LCG_DW'(LCG_MOD)) : r_d[LCG_W-1:0];
    assign last = (r_col == COL_LAST) && (r_row == ROW_LAST);

    always_comb begin
        n_state = r_state;
        case (r_state)
            FILL_MUL:  n_state = FILL_QUO;
            FILL_QUO:  n_state = FILL_REM;
            FILL_REM:  n_state = FILL_FIX;
            FILL_FIX:  n_state = (r_phase && last) ? FILL_DONE : FILL_MUL;
            FILL_DONE: n_state = FILL_DONE;
            default:   n_state = FILL_DONE;
        endcase
    end

    always_comb begin
        o_wr.we   = 1'b0;
        o_done    = 1'b0;
        case (r_state)
            FILL_FIX:  o_wr.we = r_phase;
            FILL_DONE: o_done  = 1'b1;
            default: begin
                o_wr.we = 1'b0;
                o_done  = 1'b0;
            end
        endcase
        o_wr.addr = ROM_AW'({r_row, r_col});
        o_wr.data = {r_hi, fix[15:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FILL_MUL;
            r_seed  <= LCG_SEED;
            r_phase <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == FILL_FIX) begin
                r_seed  <= fix;
                r_phase <= !r_phase;
                if (r_phase) begin
                    if (r_row == ROW_LAST) begin
                        r_row <= '0;
                        r_col <= r_col + COL_W'(1);
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            FILL_MUL: begin
                r_x <= LCG_XW'(LCG_XW'(r_seed) * LCG_XW'(LCG_MUL)) + LCG_XW'(LCG_ADD);
            end
            FILL_QUO: begin
                r_q <= LCG_QW'(((LCG_XW + 1)'(r_x) + ((LCG_XW + 1)'(r_x) << 1)) >> LCG_QSHIFT);
            end
            FILL_REM: begin
                r_d <= LCG_DW'((LCG_XW + 1)'(r_x) - (LCG_XW + 1)'(r_q) * (LCG_XW + 1)'(LCG_MOD));
            end
            FILL_FIX: begin
                if (!r_phase) begin
                    r_hi <= fix[15:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/awch_datapath.sv =====
// Second stage: decrypt and hash arithmetic on the looked-up table word,
// with the running seed registers. Depends on awch_pkg.
module awch_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  awch_pkg::t_item       i_item,
    input  logic [31:0]           i_rom_word,
    input  logic                  i_adv,
    output awch_pkg::t_result     o_result
);
    import awch_pkg::*;

    logic [WORD_W-1:0] r_dseed;
    logic [WORD_W-1:0] r_hseed_one;
    logic [WORD_W-1:0] r_hseed_two;
    logic [WORD_W-1:0] d_seed0, d_seed, d_plain, d_seed_nx;
    logic [WORD_W-1:0] h_one0, h_two0, h_one, h_two, h_one_nx, h_two_nx;
    logic              chr_nz;

    always_comb begin
        d_seed0   = i_item.start ? SEED_TWO_INIT : r_dseed;
        d_seed    = d_seed0 + i_rom_word;
        d_plain   = i_item.data ^ (i_item.key + d_seed);
        d_seed_nx = d_plain + d_seed + (d_seed << SEED_SHL) + SEED_ADD;

        h_one0    = i_item.start ? HASH_ONE_INIT : r_hseed_one;
        h_two0    = i_item.start ? SEED_TWO_INIT : r_hseed_two;
        h_one_nx  = i_rom_word ^ (h_one0 + h_two0);
        h_two_nx  = WORD_W'(i_item.chr) + h_one_nx + h_two0 + (h_two0 << SEED_SHL) + SEED_ADD;
        // a zero byte ends the name: hold the seeds
        chr_nz    = (i_item.chr != '0);
        h_one     = chr_nz ? h_one_nx : h_one0;
        h_two     = chr_nz ? h_two_nx : h_two0;

        o_result.is_hash = (i_item.action == ACT_HASH);
        o_result.word    = (i_item.action == ACT_HASH) ? h_one : d_plain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dseed     <= SEED_TWO_INIT;
            r_hseed_one <= HASH_ONE_INIT;
            r_hseed_two <= SEED_TWO_INIT;
        end else if (i_adv) begin
            if (i_item.action == ACT_HASH) begin
                r_hseed_one <= h_one;
                r_hseed_two <= h_two;
            end else begin
                r_dseed <= d_seed_nx;
            end
        end
    end

endmodule

// ===== design/archive_word_cipher_and_hash_unit.sv =====
// Archive word cipher and name hash unit. After reset the block builds its
// 1280-word crypt table in RAM and accepts no word until the table is done.
// From then on it takes one word per cycle while the output is not stalled:
// a decrypt word (tuser action 0) returns the plain word, a hash word
// (action 1) folds one name byte and returns the running first hash seed.
// The table read is registered when a word is accepted, and the word is held
// in the stage register; one arithmetic stage then feeds the output register,
// which loads whenever it is free. The sustained rate is one word per cycle;
// the single read port of the table RAM serves one lookup per word. A stalled
// result holds the input off. Depends on awch_pkg, awch_ram, awch_fill,
// awch_datapath and the defines header.
`include "archive_word_cipher_and_hash_unit_defines.svh"
module archive_word_cipher_and_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // start_req[0], cipher_key[32:1], data_in[64:33], zero fill [71:65]
    input  logic [71:0] i_s_tdata,
    // action[0], hash_kind[2:1]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // result_word[31:0]
    output logic [31:0] o_m_tdata,
    // is_hash[0]
    output logic [0:0]  o_m_tuser
);
    import awch_pkg::*;

    t_fill_wr          fill_wr;
    logic              fill_done;
    t_item             item_in;
    t_item             r_s1_item;
    logic              r_s1_valid;
    t_result           dp_result;
    t_result           r_out;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_key;
    logic [WORD_W-1:0] key_cur;
    logic [ROM_AW-1:0] rd_addr;
    logic [WORD_W-1:0] rom_word;
    logic [1:0]        hash_kind;
    logic              s_accept;
    logic              out_free;
    logic              s1_adv;
    logic              s1_free;

    awch_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (fill_wr),
        .o_done  (fill_done)
    );

    awch_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (fill_wr.we),
        .i_waddr (fill_wr.addr),
        .i_wdata (fill_wr.data),
        .i_re    (s_accept),
        .i_raddr (rd_addr),
        .o_rdata (rom_word)
    );

    awch_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (r_s1_item),
        .i_rom_word (rom_word),
        .i_adv      (s1_adv),
        .o_result   (dp_result)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && out_free;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_s_tready = fill_done && s1_free;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        hash_kind      = i_s_tuser[2:1];
        item_in.action = i_s_tuser[0];
        item_in.start  = i_s_tdata[0];
        item_in.data   = i_s_tdata[64:33];
        item_in.chr    = fold_byte(i_s_tdata[40:33]);
        // the key step does not depend on data, so the lookup index is known at accept
        key_cur        = item_in.start ? i_s_tdata[32:1] : r_key;
        item_in.key    = key_cur;
        if (item_in.action == ACT_HASH) begin
            rd_addr = ROM_AW'({hash_kind, item_in.chr});
        end else begin
            rd_addr = {KEY_QUARTER, key_cur[BYTE_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key       <= '0;
        end else begin
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (s_accept && item_in.action == ACT_DECRYPT) begin
                r_key <= key_next(key_cur);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_item <= item_in;
        end
        if (s1_adv) begin
            r_out <= dp_result;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out.word;
    assign o_m_tuser[0] = r_out.is_hash;

    `AWCH_ASSERT_IMP(a_no_accept_in_fill, o_s_tready, fill_done)
    `AWCH_ASSERT_IMP(a_no_write_after_fill, fill_done, !fill_wr.we)
    `AWCH_ASSERT_NXT(a_fill_done_sticks, fill_done, fill_done)
    `AWCH_ASSERT_NXT(a_stage_held, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_item))

endmodule
